### hw/rtl/msaa_pkg.sv
// Shared types, constants and the square-root step for the MSAA resolve block.
`timescale 1ns / 1ps

package msaa_pkg;

   localparam int NumLanes     = 3;
   localparam int ChanWidth    = 8;
   localparam int SumWidth     = 10;  // four 8-bit channels
   localparam int ProdWidth    = 18;  // sum * 255 < 2^18
   localparam int SqrtWidth    = 20;  // room for root + bit
   localparam int RootWidth    = 9;   // floor(sqrt(260100)) = 510
   localparam int SqrtSteps    = 10;
   localparam int StepsPerStage = 5;

   localparam logic [SqrtWidth-1:0] SqrtTopBit = SqrtWidth'(1) << 18;

   // bit offset of the red, green, blue bytes inside a sample
   localparam int LaneShift [NumLanes] = '{24, 16, 8};

   typedef struct packed {
      logic [SqrtWidth-1:0] rem;
      logic [SqrtWidth-1:0] root;
   } sqrt_state_type;

   // one digit of the restoring integer square root
   function automatic sqrt_state_type sqrt_step(sqrt_state_type s,
                                                logic [SqrtWidth-1:0] bit_val);
      sqrt_state_type       n;
      logic [SqrtWidth-1:0] trial;
      trial = s.root + bit_val;
      if (s.rem >= trial) begin
         n.rem  = s.rem - trial;
         n.root = (s.root >> 1) + bit_val;
      end else begin
         n.rem  = s.rem;
         n.root = s.root >> 1;
      end
      return n;
   endfunction

endpackage

### hw/rtl/msaa_lane.sv
// One colour lane: channel sum, scale by 255, two-stage square root, rounding.
`timescale 1ns / 1ps

module msaa_lane (
   input  logic                            clock,
   input  logic                            en,
   input  logic [msaa_pkg::ChanWidth-1:0]  chan_a,
   input  logic [msaa_pkg::ChanWidth-1:0]  chan_b,
   input  logic [msaa_pkg::ChanWidth-1:0]  chan_c,
   input  logic [msaa_pkg::ChanWidth-1:0]  chan_d,
   output logic [msaa_pkg::ChanWidth-1:0]  chan_out
);
   import msaa_pkg::*;

   logic [SumWidth-1:0]  sum;
   logic [ProdWidth-1:0] prod_in, prod_ff;
   sqrt_state_type       mid_in, mid_ff;
   sqrt_state_type       fin;
   logic [RootWidth:0]   rounded;
   logic [ChanWidth-1:0] chan_in, chan_ff;

   // S*255 as S*256 - S
   always_comb begin
      sum = SumWidth'(chan_a) + SumWidth'(chan_b) + SumWidth'(chan_c) + SumWidth'(chan_d);
      prod_in = {sum, 8'b0} - ProdWidth'(sum);
   end

   // upper five digits
   always_comb begin
      mid_in.rem  = SqrtWidth'(prod_ff);
      mid_in.root = '0;
      for (int k = 0; k < StepsPerStage; k++) begin
         mid_in = sqrt_step(mid_in, SqrtTopBit >> (2 * k));
      end
   end

   // lower five digits, then round half up of root/2
   always_comb begin
      fin = mid_ff;
      for (int k = StepsPerStage; k < SqrtSteps; k++) begin
         fin = sqrt_step(fin, SqrtTopBit >> (2 * k));
      end
      rounded = {1'b0, fin.root[RootWidth-1:0]} + (RootWidth+1)'(1);
      chan_in = rounded[ChanWidth:1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         mid_ff  <= mid_in;
         chan_ff <= chan_in;
      end
   end

   assign chan_out = chan_ff;

endmodule

### hw/rtl/msaa_resolve_sqrt_gamma.sv
// Top level: three colour lanes side by side and the packing output register.
//
// 4x MSAA box resolve with square-root gamma encode.
// Input channel req_*: one beat carries the four samples of one pixel
// (R 31:24, G 23:16, B 15:8; the low byte is ignored).
// Output channel rsp_*: one beat carries the resolved pixel, low byte zero.
// Red, green and blue each run in their own lane: sum and scale by 255,
// then two stages of five square-root digits each; the lanes meet in the
// output register, which packs the three bytes.
// Throughput is one pixel per clock while rsp_ready stays high.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, req_ready drops in the same cycle and every stage holds.
// A synchronous reset empties the pipeline; rsp_valid is low afterwards.
`timescale 1ns / 1ps

module msaa_resolve_sqrt_gamma (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_sample_a,
   input  logic [31:0] req_sample_b,
   input  logic [31:0] req_sample_c,
   input  logic [31:0] req_sample_d,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_resolved_pixel
);
   import msaa_pkg::*;

   logic                 en;
   logic                 v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic                 out_valid_ff, out_valid_in;
   logic [31:0]          pixel_in, pixel_ff;
   logic [ChanWidth-1:0] lane_out [NumLanes];

   assign en = !out_valid_ff || rsp_ready;

   for (genvar g = 0; g < NumLanes; g++) begin : g_lane
      msaa_lane u_lane (
         .clock    (clock),
         .en       (en),
         .chan_a   (req_sample_a[LaneShift[g] +: ChanWidth]),
         .chan_b   (req_sample_b[LaneShift[g] +: ChanWidth]),
         .chan_c   (req_sample_c[LaneShift[g] +: ChanWidth]),
         .chan_d   (req_sample_d[LaneShift[g] +: ChanWidth]),
         .chan_out (lane_out[g])
      );
   end

   always_comb begin
      v1_in        = req_valid;
      v2_in        = v1_ff;
      v3_in        = v2_ff;
      out_valid_in = v3_ff;
      pixel_in     = {lane_out[0], lane_out[1], lane_out[2], 8'h00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pixel_ff <= pixel_in;
      end
   end

   assign req_ready          = en;
   assign rsp_valid          = out_valid_ff;
   assign rsp_resolved_pixel = pixel_ff;

   // the pipeline only stalls when a result sits unclaimed
   a_ready_tracks_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready out of step with output register");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("accepted beat lost at first stage");

   a_last_stage_delivers: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && en) |=> rsp_valid)
      else $error("last stage beat lost before output register");

   a_low_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_resolved_pixel[7:0] == 8'h00))
      else $error("resolved pixel low byte not zero");

endmodule

### dv/testbench.sv
// Self-checking testbench for the 4x MSAA resolve with square-root gamma.
`timescale 1ns / 1ps

module testbench;

   localparam int CycleLimit  = 200000;
   localparam int NumDirected = 18;
   localparam int HoldCycles  = 100;

   typedef struct packed {
      logic [31:0] sample_a;
      logic [31:0] sample_b;
      logic [31:0] sample_c;
      logic [31:0] sample_d;
      logic        typed;       // expected pixel given in the row
      logic [31:0] pixel;
   } pixel_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_sample_a = '0;
   logic [31:0] req_sample_b = '0;
   logic [31:0] req_sample_c = '0;
   logic [31:0] req_sample_d = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_resolved_pixel;

   // expectation carried alongside the request beat for typed-in rows
   logic        req_typed = 1'b0;
   logic [31:0] req_typed_pixel = '0;

   int          send_idle_pct = 20;
   int          recv_idle_pct = 56;
   logic        hold_request = 1'b0;
   logic        hold_done = 1'b0;
   int          hold_left = 0;
   int          cycle_count = 0;
   int          mismatch_count = 0;
   logic [31:0] expected_pixels [$];

   pixel_row_type directed_rows [NumDirected] = '{
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FF00},
      // low byte must be ignored
      '{32'h0000_00FF, 32'h0000_00FF, 32'h0000_00FF, 32'h0000_00FF, 1'b1, 32'h0000_0000},
      '{32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000, 1'b1, 32'hFF00_0000},
      '{32'h00FF_0000, 32'h00FF_0000, 32'h00FF_0000, 32'h00FF_0000, 1'b1, 32'h00FF_0000},
      '{32'h0000_FF00, 32'h0000_FF00, 32'h0000_FF00, 32'h0000_FF00, 1'b1, 32'h0000_FF00},
      '{32'hFFFF_FF00, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h8080_8000},
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8080_8000},
      '{32'h0101_0100, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
      '{32'h0102_0300, 32'h0102_0300, 32'h0102_0300, 32'h0102_0300, 1'b0, 32'h0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0},
      '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0},
      '{32'h8080_8080, 32'h8080_8080, 32'h8080_8080, 32'h8080_8080, 1'b0, 32'h0},
      '{32'h7F7F_7F7F, 32'h7F7F_7F7F, 32'h7F7F_7F7F, 32'h7F7F_7F7F, 1'b0, 32'h0},
      '{32'hFEFD_FC01, 32'h0102_0304, 32'hF0E0_D0C0, 32'h0F1F_2F3F, 1'b0, 32'h0},
      '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F1E_2D3C, 32'hC3D2_E1F0, 1'b0, 32'h0},
      // one short of full scale on every channel
      '{32'hFFFF_FF00, 32'hFFFF_FF00, 32'hFFFF_FF00, 32'hFEFE_FE00, 1'b0, 32'h0},
      '{32'hFF00_FF00, 32'h00FF_00FF, 32'hFF00_FF00, 32'h00FF_00FF, 1'b0, 32'h0}
   };

   msaa_resolve_sqrt_gamma u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample_a       (req_sample_a),
      .req_sample_b       (req_sample_b),
      .req_sample_c       (req_sample_c),
      .req_sample_d       (req_sample_d),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_resolved_pixel (rsp_resolved_pixel)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // round(sqrt(sum * 255) / 2) with an exact integer root
   function automatic logic [7:0] gamma_byte(input int chan_sum);
      int scaled;
      int root;
      scaled = chan_sum * 255;
      root   = 0;
      while ((root + 1) * (root + 1) <= scaled)
         root++;
      return 8'((root + 1) >> 1);
   endfunction

   function automatic logic [31:0] resolve_pixel(input logic [31:0] a, input logic [31:0] b,
                                                 input logic [31:0] c, input logic [31:0] d);
      logic [31:0] pixel;
      int          shift;
      pixel = '0;
      for (shift = 8; shift <= 24; shift += 8)
         pixel[shift +: 8] = gamma_byte(int'(a[shift +: 8]) + int'(b[shift +: 8]) +
                                        int'(c[shift +: 8]) + int'(d[shift +: 8]));
      return pixel;
   endfunction

   // a third of the samples get some channels forced to the rails
   function automatic logic [31:0] random_sample();
      logic [31:0] s;
      int          i;
      s = $urandom;
      if ($urandom_range(0, 2) == 0) begin
         for (i = 1; i < 4; i++) begin
            case ($urandom_range(0, 2))
               0: begin
                  s[8*i +: 8] = 8'h00;
               end
               1: begin
                  s[8*i +: 8] = 8'hFF;
               end
               default: begin
               end
            endcase
         end
      end
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // called just after an edge; returns just after the edge that took the beat
   task automatic push_pixel(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
                             input logic [31:0] d, input logic typed, input logic [31:0] pixel);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample_a    <= a;
      req_sample_b    <= b;
      req_sample_c    <= c;
      req_sample_d    <= d;
      req_typed       <= typed;
      req_typed_pixel <= pixel;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic push_random(input int count);
      int n;
      for (n = 0; n < count; n++)
         push_pixel(random_sample(), random_sample(), random_sample(), random_sample(),
                    1'b0, 32'h0);
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         // long back-pressure so the pipeline fills and req_ready drops
         rsp_ready <= 1'b0;
         hold_left <= HoldCycles;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : result_check
      logic [31:0] want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_pixels.push_back(req_typed ? req_typed_pixel :
               resolve_pixel(req_sample_a, req_sample_b, req_sample_c, req_sample_d));
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected beat", rsp_resolved_pixel, 32'h0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_resolved_pixel !== want)
                  report_mismatch("resolved_pixel", rsp_resolved_pixel, want);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int k;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < NumDirected; k++)
         push_pixel(directed_rows[k].sample_a, directed_rows[k].sample_b,
                    directed_rows[k].sample_c, directed_rows[k].sample_d,
                    directed_rows[k].typed, directed_rows[k].pixel);
      push_random(220);

      send_idle_pct = 56;
      recv_idle_pct = 20;
      push_random(220);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request <= 1'b1;
      push_random(210);
      req_valid <= 1'b0;

      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
